FILE: rtl/core/wpgc_pkg.sv
// ----------------------------------------------------------------------------
// Welsh-Powell coloring package
// Shared widths, command codes and the graph store control bundle.
// ----------------------------------------------------------------------------
package wpgc_pkg;

   // Graph size and field widths
   localparam int MAX_VERTICES = 32;
   localparam int VTX_W        = 5;   // vertex index
   localparam int CNT_W        = 6;   // vertex count, color count
   localparam int DEG_W        = 8;   // saturating degree
   localparam logic [DEG_W-1:0] DEG_MAX = 8'hFF;

   // Stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // Command codes carried in req_tuser
   localparam logic CMD_ADD_EDGE = 1'b0;
   localparam logic CMD_START    = 1'b1;

   // Control bundle from the sequencer to the graph store
   typedef struct packed {
      logic             add;    // set bit col in row addr, bump degree of addr
      logic             clear;  // zero every row and degree
      logic [VTX_W-1:0] col;
   } store_ctl_type;

endpackage

FILE: rtl/core/wpgc_store.sv
// ----------------------------------------------------------------------------
// Welsh-Powell graph store
// Adjacency bit matrix and saturating degree counters, one shared address.
// ----------------------------------------------------------------------------
module wpgc_store
   import wpgc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  store_ctl_type           ctl,
   input  logic [VTX_W-1:0]        addr,
   output logic [MAX_VERTICES-1:0] row,
   output logic [DEG_W-1:0]        degree
);

   logic [MAX_VERTICES-1:0] adj_ff [MAX_VERTICES];
   logic [DEG_W-1:0]        deg_ff [MAX_VERTICES];

   // Read the addressed row and degree
   assign row    = adj_ff[addr];
   assign degree = deg_ff[addr];

   // Set one adjacency bit and bump one degree, or wipe the store
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            adj_ff[i] <= '0;
            deg_ff[i] <= '0;
         end
      end else if (ctl.add) begin
         adj_ff[addr][ctl.col] <= 1'b1;
         if (deg_ff[addr] != DEG_MAX) begin
            deg_ff[addr] <= deg_ff[addr] + DEG_W'(1);
         end
      end
   end

endmodule

FILE: rtl/core/welsh_powell_graph_coloring_unit.sv
// ----------------------------------------------------------------------------
// Welsh-Powell graph coloring unit
// Edge loading, degree ordering, greedy coloring rounds and result stream.
// ----------------------------------------------------------------------------
// An edge beat is accepted in ST_IDLE, then ST_ADD_A and ST_ADD_B each make
// one store update per endpoint; an edge with an endpoint at or above the
// vertex count is dropped in the accept cycle. A start beat with n active
// vertices keeps req_tready low through selection sort (one degree compare
// per cycle), then coloring (one visited vertex per cycle, one round per
// color), then streams n result beats at up to one per cycle while
// rsp_tready allows, then wipes the graph store in ST_CLEAR.
module welsh_powell_graph_coloring_unit
   import wpgc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Configuration: vertex_count
   input  logic                  csr_we,
   input  logic [CNT_W-1:0]      csr_wdata,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // vertex_a[4:0], vertex_b[9:5], zero pad
   input  logic                  req_tuser,   // command[0]
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // vertex[4:0], degree[12:5],
                                              // color[17:13], colors_used[23:18]
   output logic                  rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_A,
      ST_ADD_B,
      ST_SORT,
      ST_COLOR,
      ST_EMIT,
      ST_CLEAR
   } state_type;

   // Sequencer registers
   state_type               state_ff,     state_in;
   logic [CNT_W-1:0]        vcount_ff,    vcount_in;
   logic [VTX_W-1:0]        a_ff,         a_in;
   logic [VTX_W-1:0]        b_ff,         b_in;
   logic [VTX_W-1:0]        scan_ff,      scan_in;
   logic [VTX_W-1:0]        pos_ff,       pos_in;
   logic [VTX_W-1:0]        best_ff,      best_in;
   logic [DEG_W-1:0]        best_deg_ff,  best_deg_in;
   logic                    have_best_ff, have_best_in;
   logic [MAX_VERTICES-1:0] placed_ff,    placed_in;
   logic [MAX_VERTICES-1:0] colored_ff,   colored_in;
   logic [MAX_VERTICES-1:0] mask_ff,      mask_in;
   logic [CNT_W-1:0]        cur_ff,       cur_in;
   logic [CNT_W-1:0]        left_ff,      left_in;
   logic [CNT_W-1:0]        out_idx_ff,   out_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VTX_W-1:0]        rsp_vertex_ff, rsp_vertex_in;
   logic [DEG_W-1:0]        rsp_degree_ff, rsp_degree_in;
   logic [VTX_W-1:0]        rsp_color_ff,  rsp_color_in;
   logic [CNT_W-1:0]        rsp_colors_ff, rsp_colors_in;
   logic                    rsp_last_ff,   rsp_last_in;

   // Visit order and assigned colors (no reset needed)
   logic [VTX_W-1:0] order_ff [MAX_VERTICES];
   logic [VTX_W-1:0] color_ff [MAX_VERTICES];
   logic             order_we;
   logic             color_we;

   // Store interface
   store_ctl_type           st_ctl;
   logic [VTX_W-1:0]        st_addr;
   logic [MAX_VERTICES-1:0] st_row;
   logic [DEG_W-1:0]        st_deg;

   // Derived values
   logic [CNT_W-1:0] n_eff;
   logic [CNT_W-1:0] n_m1;
   logic [VTX_W-1:0] n_last;
   logic [VTX_W-1:0] req_a;
   logic [VTX_W-1:0] req_b;
   logic             req_fire;
   logic             sort_take;
   logic [VTX_W-1:0] sort_pick;
   logic [VTX_W-1:0] cv;
   logic             cv_free;
   logic [CNT_W-1:0] left_next;
   logic             rsp_adv;

   assign n_eff  = (vcount_ff > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_ff;
   assign n_m1   = n_eff - CNT_W'(1);
   assign n_last = n_m1[VTX_W-1:0];
   assign req_a  = req_tdata[VTX_W-1:0];
   assign req_b  = req_tdata[2*VTX_W-1:VTX_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Shared compare: keep the scanned vertex if unplaced and not below the best
   assign sort_take = !placed_ff[scan_ff] && (!have_best_ff || (st_deg >= best_deg_ff));
   assign sort_pick = sort_take ? scan_ff : best_ff;

   // Coloring test for the visited vertex against this round's holders
   assign cv        = order_ff[pos_ff];
   assign cv_free   = !colored_ff[cv] && ((st_row & mask_ff) == '0);
   assign left_next = left_ff + CNT_W'(cv_free);

   assign rsp_adv = !rsp_valid_ff || rsp_tready;

   wpgc_store u_store (
      .clock  (clock),
      .reset  (reset),
      .ctl    (st_ctl),
      .addr   (st_addr),
      .row    (st_row),
      .degree (st_deg)
   );

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      vcount_in     = vcount_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      best_in       = best_ff;
      best_deg_in   = best_deg_ff;
      have_best_in  = have_best_ff;
      placed_in     = placed_ff;
      colored_in    = colored_ff;
      mask_in       = mask_ff;
      cur_in        = cur_ff;
      left_in       = left_ff;
      out_idx_in    = out_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_degree_in = rsp_degree_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_colors_in = rsp_colors_ff;
      rsp_last_in   = rsp_last_ff;
      order_we      = 1'b0;
      color_we      = 1'b0;
      st_ctl        = '0;
      st_addr       = a_ff;

      if (csr_we) begin
         vcount_in = csr_wdata;
      end

      case (state_ff)
         // Take a beat: start a run or register an in-range edge
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == CMD_START) begin
                  scan_in      = '0;
                  pos_in       = '0;
                  placed_in    = '0;
                  have_best_in = 1'b0;
                  state_in     = (n_eff == '0) ? ST_CLEAR : ST_SORT;
               end else if (({1'b0, req_a} < n_eff) && ({1'b0, req_b} < n_eff)) begin
                  a_in     = req_a;
                  b_in     = req_b;
                  state_in = ST_ADD_A;
               end
            end
         end

         // Update the first endpoint's row and degree
         ST_ADD_A: begin
            st_addr    = a_ff;
            st_ctl.add = 1'b1;
            st_ctl.col = b_ff;
            state_in   = ST_ADD_B;
         end

         // Update the second endpoint's row and degree
         ST_ADD_B: begin
            st_addr    = b_ff;
            st_ctl.add = 1'b1;
            st_ctl.col = a_ff;
            state_in   = ST_IDLE;
         end

         // Selection sort: one vertex compared per cycle
         ST_SORT: begin
            st_addr = scan_ff;
            if (sort_take) begin
               best_in      = scan_ff;
               best_deg_in  = st_deg;
               have_best_in = 1'b1;
            end
            if (scan_ff == n_last) begin
               order_we           = 1'b1;
               placed_in[sort_pick] = 1'b1;
               have_best_in       = 1'b0;
               scan_in            = '0;
               if (pos_ff == n_last) begin
                  pos_in     = '0;
                  cur_in     = '0;
                  left_in    = '0;
                  mask_in    = '0;
                  colored_in = '0;
                  state_in   = ST_COLOR;
               end else begin
                  pos_in = pos_ff + VTX_W'(1);
               end
            end else begin
               scan_in = scan_ff + VTX_W'(1);
            end
         end

         // Coloring round: visit one vertex of the order per cycle
         ST_COLOR: begin
            st_addr = cv;
            if (cv_free) begin
               color_we        = 1'b1;
               colored_in[cv]  = 1'b1;
               mask_in[cv]     = 1'b1;
               left_in         = left_next;
            end
            if (pos_ff == n_last) begin
               pos_in  = '0;
               cur_in  = cur_ff + CNT_W'(1);
               mask_in = '0;
               if (left_next == n_eff) begin
                  out_idx_in = '0;
                  state_in   = ST_EMIT;
               end
            end else begin
               pos_in = pos_ff + VTX_W'(1);
            end
         end

         // Stream one result beat per vertex in index order
         ST_EMIT: begin
            st_addr = out_idx_ff[VTX_W-1:0];
            if (rsp_adv) begin
               if (out_idx_ff < n_eff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_vertex_in = out_idx_ff[VTX_W-1:0];
                  rsp_degree_in = st_deg;
                  rsp_color_in  = color_ff[out_idx_ff[VTX_W-1:0]];
                  rsp_colors_in = cur_ff;
                  rsp_last_in   = (out_idx_ff == n_m1);
                  out_idx_in    = out_idx_ff + CNT_W'(1);
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_CLEAR;
               end
            end
         end

         // Wipe the graph store and the colored marks
         ST_CLEAR: begin
            st_ctl.clear = 1'b1;
            colored_in   = '0;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= '0;
         have_best_ff <= 1'b0;
         placed_ff    <= '0;
         colored_ff   <= '0;
         mask_ff      <= '0;
         cur_ff       <= '0;
         left_ff      <= '0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         have_best_ff <= have_best_in;
         placed_ff    <= placed_in;
         colored_ff   <= colored_in;
         mask_ff      <= mask_in;
         cur_ff       <= cur_in;
         left_ff      <= left_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff          <= a_in;
      b_ff          <= b_in;
      scan_ff       <= scan_in;
      pos_ff        <= pos_in;
      best_ff       <= best_in;
      best_deg_ff   <= best_deg_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_degree_ff <= rsp_degree_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_colors_ff <= rsp_colors_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Write the visit order and the assigned colors
   always_ff @(posedge clock) begin
      if (order_we) begin
         order_ff[pos_ff] <= sort_pick;
      end
      if (color_we) begin
         color_ff[cv] <= cur_ff[VTX_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_colors_ff, rsp_color_ff, rsp_degree_ff, rsp_vertex_ff};

endmodule

FILE: rtl/core/wpgc_checker.sv
// ----------------------------------------------------------------------------
// Welsh-Powell coloring port checker
// Checks the result stream and channel interplay seen at the top-level ports.
// ----------------------------------------------------------------------------
module wpgc_port_checker
   import wpgc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tready,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast
);

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // No request is taken while results stream
   a_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request ready while results pending");

   // A run streams without gaps until its last beat
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside result run");

   // The stream ends after the last beat
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("beat after last result");

   // Every color lies below the color count
   a_color: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[17:13]} < rsp_tdata[23:18]))
      else $error("color not below colors used");

endmodule

bind welsh_powell_graph_coloring_unit wpgc_port_checker u_wpgc_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
